FILE: rtl/mpe_pkg.sv
// Package for the Mandelbrot pixel escape block: fixed-point constants,
// configuration, controller state, datapath command and status types.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package mpe_pkg;

  // Fixed-point format of the working word (signed Q4.28).
  localparam int FRAC_BITS = 28;
  localparam int WORD_BITS = FRAC_BITS + 4;
  // Operand width of each datapath multiplier (signed).
  localparam int MUL_BITS  = 33;
  localparam int PROD_BITS = 2 * MUL_BITS;
  // Low slice of the pre-scale coordinate that is multiplied separately.
  localparam int LO_BITS   = 24;
  // Width of a square shifted back to the working scale (not saturated).
  localparam int SQ_BITS   = 2 * WORD_BITS - FRAC_BITS;
  // Width of the sums formed in one iteration step.
  localparam int ITER_BITS = SQ_BITS + 2;

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Configuration register indexes (byte address is 4 times the index).
  localparam int REG_IDX_BITS = 3;
  localparam int ADDR_BITS    = 5;
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_MIN_RE     = 3'd0,
    REG_MAX_IM     = 3'd1,
    REG_RE_STEP    = 3'd2,
    REG_IM_STEP    = 3'd3,
    REG_ZOOM_SCALE = 3'd4,
    REG_MAX_ITER   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] min_re;
    logic [31:0] max_im;
    logic [30:0] re_step;
    logic [30:0] im_step;
    logic [30:0] zoom_scale;
    logic [15:0] max_iterations;
  } cfg_t;

  // Controller states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_MUL_XY   = 9'b000000010,
    ST_SUM      = 9'b000000100,
    ST_MUL_RE   = 9'b000001000,
    ST_MUL_IM   = 9'b000010000,
    ST_FIX_IM   = 9'b000100000,
    ST_ITER_MUL = 9'b001000000,
    ST_ITER_UPD = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_MUL_XY   = 4'd2,
    OP_SUM      = 4'd3,
    OP_MUL_RE   = 4'd4,
    OP_MUL_IM   = 4'd5,
    OP_FIX_IM   = 4'd6,
    OP_ITER_MUL = 4'd7,
    OP_ITER_UPD = 4'd8
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
    logic in_set;
  } cmd_t;

  typedef struct packed {
    logic escaped;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/mpe_regs.sv
// Configuration register file with an APB-style write/read port.
// Depends on mpe_pkg for the register indexes and the cfg_t bundle.
module mpe_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpe_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output mpe_pkg::cfg_t                cfg
);

  logic                             wr_en;
  logic [mpe_pkg::REG_IDX_BITS-1:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[mpe_pkg::ADDR_BITS-1:2];

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_re         <= 32'hE000_0000;
      cfg.max_im         <= 32'h1000_0000;
      cfg.re_step        <= 31'd786432;
      cfg.im_step        <= 31'd786432;
      cfg.zoom_scale     <= 31'h1000_0000;
      cfg.max_iterations <= 16'd256;
    end else if (wr_en) begin
      case (idx)
        mpe_pkg::REG_MIN_RE:     cfg.min_re         <= pwdata;
        mpe_pkg::REG_MAX_IM:     cfg.max_im         <= pwdata;
        mpe_pkg::REG_RE_STEP:    cfg.re_step        <= pwdata[30:0];
        mpe_pkg::REG_IM_STEP:    cfg.im_step        <= pwdata[30:0];
        mpe_pkg::REG_ZOOM_SCALE: cfg.zoom_scale     <= pwdata[30:0];
        mpe_pkg::REG_MAX_ITER:   cfg.max_iterations <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register, zero-extended.
  always_comb begin
    case (idx)
      mpe_pkg::REG_MIN_RE:     prdata = cfg.min_re;
      mpe_pkg::REG_MAX_IM:     prdata = cfg.max_im;
      mpe_pkg::REG_RE_STEP:    prdata = {1'b0, cfg.re_step};
      mpe_pkg::REG_IM_STEP:    prdata = {1'b0, cfg.im_step};
      mpe_pkg::REG_ZOOM_SCALE: prdata = {1'b0, cfg.zoom_scale};
      mpe_pkg::REG_MAX_ITER:   prdata = {16'd0, cfg.max_iterations};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/mpe_ctrl.sv
// Controller state machine: sequences coordinate mapping, the escape
// iterations and the result transfer. Depends on mpe_pkg.
module mpe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       max_iter,
  input  mpe_pkg::status_t  status,
  output mpe_pkg::cmd_t     cmd
);

  mpe_pkg::state_t state, state_next;
  logic [15:0]     count, count_next;
  logic            in_set, in_set_next;

  assign in_ready = (state == mpe_pkg::ST_IDLE);

  // Next state, iteration count and command decode.
  always_comb begin
    state_next   = state;
    count_next   = count;
    in_set_next  = in_set;
    cmd.op       = mpe_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    cmd.in_set   = in_set;
    unique case (state)
      mpe_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = mpe_pkg::OP_LOAD;
          count_next = 16'd0;
          state_next = mpe_pkg::ST_MUL_XY;
        end
      end
      mpe_pkg::ST_MUL_XY: begin
        cmd.op     = mpe_pkg::OP_MUL_XY;
        state_next = mpe_pkg::ST_SUM;
      end
      mpe_pkg::ST_SUM: begin
        cmd.op     = mpe_pkg::OP_SUM;
        state_next = mpe_pkg::ST_MUL_RE;
      end
      mpe_pkg::ST_MUL_RE: begin
        cmd.op     = mpe_pkg::OP_MUL_RE;
        state_next = mpe_pkg::ST_MUL_IM;
      end
      mpe_pkg::ST_MUL_IM: begin
        cmd.op     = mpe_pkg::OP_MUL_IM;
        state_next = mpe_pkg::ST_FIX_IM;
      end
      mpe_pkg::ST_FIX_IM: begin
        cmd.op     = mpe_pkg::OP_FIX_IM;
        state_next = mpe_pkg::ST_ITER_MUL;
      end
      mpe_pkg::ST_ITER_MUL: begin
        // The limit is checked before each step; reaching it means inside.
        if (count == max_iter) begin
          in_set_next = 1'b1;
          state_next  = mpe_pkg::ST_DONE;
        end else begin
          cmd.op     = mpe_pkg::OP_ITER_MUL;
          state_next = mpe_pkg::ST_ITER_UPD;
        end
      end
      mpe_pkg::ST_ITER_UPD: begin
        cmd.op = mpe_pkg::OP_ITER_UPD;
        if (status.escaped) begin
          in_set_next = 1'b0;
          state_next  = mpe_pkg::ST_DONE;
        end else begin
          count_next = count + 16'd1;
          state_next = mpe_pkg::ST_ITER_MUL;
        end
      end
      mpe_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = mpe_pkg::ST_IDLE;
        end
      end
      default: state_next = mpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mpe_pkg::ST_IDLE;
      count  <= 16'd0;
      in_set <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      in_set <= in_set_next;
    end
  end

endmodule

FILE: rtl/mpe_datapath.sv
// Datapath: three registered 33x33 multipliers, coordinate mapping with
// saturation, the z = z^2 + c step, escape test and the output register.
// Depends on mpe_pkg for widths, commands and status.
module mpe_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mpe_pkg::cfg_t         cfg,
  input  mpe_pkg::cmd_t         cmd,
  output mpe_pkg::status_t      status,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic                  inside_res
);

  // Pre-scale coordinate: min_re + x*re_step needs COORD_BITS+33 bits signed.
  localparam int A_BITS    = COORD_BITS + 33;
  localparam int FULL_BITS = A_BITS + 32;
  localparam int WB        = mpe_pkg::WORD_BITS;
  localparam int FB        = mpe_pkg::FRAC_BITS;
  localparam int MB        = mpe_pkg::MUL_BITS;
  localparam int PB        = mpe_pkg::PROD_BITS;
  localparam int IB        = mpe_pkg::ITER_BITS;

  localparam logic signed [FULL_BITS-1:0] FULL_MAX = FULL_BITS'(mpe_pkg::WORD_MAX);
  localparam logic signed [FULL_BITS-1:0] FULL_MIN = FULL_BITS'(mpe_pkg::WORD_MIN);
  localparam logic signed [IB-1:0]        ITER_MAX = IB'(mpe_pkg::WORD_MAX);
  localparam logic signed [IB-1:0]        ITER_MIN = IB'(mpe_pkg::WORD_MIN);
  localparam logic signed [IB-1:0]        FOUR     = IB'(4) <<< FB;

  // Scale-down by the fraction bits and clamp to the working word.
  function automatic logic [WB-1:0] sat_fix(input logic signed [FULL_BITS-1:0] v);
    logic signed [FULL_BITS-1:0] sh;
    logic [WB-1:0]               r;
    sh = v >>> FB;
    if (sh > FULL_MAX)      r = mpe_pkg::WORD_MAX;
    else if (sh < FULL_MIN) r = mpe_pkg::WORD_MIN;
    else                    r = sh[WB-1:0];
    return r;
  endfunction

  function automatic logic [WB-1:0] sat_iter(input logic signed [IB-1:0] v);
    logic [WB-1:0] r;
    if (v > ITER_MAX)      r = mpe_pkg::WORD_MAX;
    else if (v < ITER_MIN) r = mpe_pkg::WORD_MIN;
    else                   r = v[WB-1:0];
    return r;
  endfunction

  logic [COORD_BITS-1:0]       pix_x, pix_y;
  logic signed [A_BITS-1:0]    a_re, a_im;
  logic signed [PB-1:0]        prod0, prod1, prod2;
  logic signed [WB-1:0]        cre, cim, zr, zi;
  logic signed [MB-1:0]        ma0, mb0, ma1, mb1, ma2, mb2;
  logic signed [FULL_BITS-1:0] full;
  logic [WB-1:0]               fixed;
  logic signed [IB-1:0]        zr2, zi2, zrzi2;
  logic signed [IB-1:0]        mag, zr_sum, zi_sum;
  logic                        mul_en;

  // Operand selection for the three multipliers.
  always_comb begin
    ma0    = '0;
    mb0    = '0;
    ma1    = '0;
    mb1    = '0;
    ma2    = '0;
    mb2    = '0;
    mul_en = 1'b0;
    unique case (cmd.op)
      mpe_pkg::OP_MUL_XY: begin
        mul_en = 1'b1;
        ma0    = MB'(pix_x);
        mb0    = MB'(cfg.re_step);
        ma1    = MB'(pix_y);
        mb1    = MB'(cfg.im_step);
      end
      mpe_pkg::OP_MUL_RE: begin
        mul_en = 1'b1;
        ma0    = MB'(a_re[mpe_pkg::LO_BITS-1:0]);
        mb0    = MB'(cfg.zoom_scale);
        ma1    = MB'(signed'(a_re[A_BITS-1:mpe_pkg::LO_BITS]));
        mb1    = MB'(cfg.zoom_scale);
      end
      mpe_pkg::OP_MUL_IM: begin
        mul_en = 1'b1;
        ma0    = MB'(a_im[mpe_pkg::LO_BITS-1:0]);
        mb0    = MB'(cfg.zoom_scale);
        ma1    = MB'(signed'(a_im[A_BITS-1:mpe_pkg::LO_BITS]));
        mb1    = MB'(cfg.zoom_scale);
      end
      mpe_pkg::OP_ITER_MUL: begin
        mul_en = 1'b1;
        ma0    = MB'(zr);
        mb0    = MB'(zr);
        ma1    = MB'(zi);
        mb1    = MB'(zi);
        ma2    = MB'(zr);
        mb2    = MB'(zi);
      end
      default: ;
    endcase
  end

  // Recombine the split scale products and saturate.
  assign full  = (FULL_BITS'(prod1) <<< mpe_pkg::LO_BITS) + FULL_BITS'(prod0);
  assign fixed = sat_fix(full);

  // Iteration step: squares and doubled cross product back at Q4.28 scale.
  assign zr2    = IB'(signed'(prod0[2*WB-1:FB]));
  assign zi2    = IB'(signed'(prod1[2*WB-1:FB]));
  assign zrzi2  = IB'(signed'(prod2[2*WB-1:FB-1]));
  assign mag    = zr2 + zi2;
  assign zr_sum = zr2 - zi2 + IB'(cre);
  assign zi_sum = zrzi2 + IB'(cim);

  assign status.escaped  = (mag > FOUR);
  assign status.out_free = !out_valid || out_ready;

  // Working registers.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod0 <= ma0 * mb0;
      prod1 <= ma1 * mb1;
      prod2 <= ma2 * mb2;
    end
    unique case (cmd.op)
      mpe_pkg::OP_LOAD: begin
        pix_x <= pixel_x;
        pix_y <= pixel_y;
      end
      mpe_pkg::OP_SUM: begin
        a_re <= A_BITS'(signed'(cfg.min_re)) + A_BITS'(prod0);
        a_im <= A_BITS'(signed'(cfg.max_im)) - A_BITS'(prod1);
      end
      mpe_pkg::OP_MUL_IM: cre <= fixed;
      mpe_pkg::OP_FIX_IM: begin
        cim <= fixed;
        zr  <= cre;
        zi  <= fixed;
      end
      mpe_pkg::OP_ITER_UPD: begin
        zr <= sat_iter(zr_sum);
        zi <= sat_iter(zi_sum);
      end
      default: ;
    endcase
  end

  // Output register; holds the result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x      <= pix_x;
      out_y      <= pix_y;
      inside_res <= cmd.in_set;
    end
  end

endmodule

FILE: rtl/mandelbrot_pixel_escape.sv
// Top level of the Mandelbrot pixel escape block: stream ports, register
// port, controller and datapath. Depends on mpe_pkg, mpe_regs, mpe_ctrl,
// mpe_datapath.
//
//  port group   direction  contents
//  s_*          in         pixel coordinate in, one per transfer
//  m_*          out        coordinate and inside flag, one per input
//  p*           in/out     configuration registers, APB-style
//
// The result is loaded after the escape test fires or the step limit ends the
// iteration: the mapping runs through MUL_XY, SUM, MUL_RE, MUL_IM and FIX_IM,
// then each step has a multiply state and a state of add, test and saturation.
// Reset is synchronous and restores the defaults.
// The next pixel is taken once the previous result sits in the output register;
// a stalled output holds the controller only once the following pixel is done.
module mandelbrot_pixel_escape #(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // pixel_x, pixel_y from bit 0 up, zero padding
  input  logic [8*((2*COORD_BITS+7)/8)-1:0]      s_tdata,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // out_x, out_y, inside_res from bit 0 up, zero padding
  output logic [8*((2*COORD_BITS+8)/8)-1:0]      m_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mpe_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int OUT_W = 8 * ((2 * COORD_BITS + 8) / 8);

  mpe_pkg::cfg_t         cfg;
  mpe_pkg::cmd_t         cmd;
  mpe_pkg::status_t      status;
  logic [COORD_BITS-1:0] out_x, out_y;
  logic                  inside_res;

  assign pready = 1'b1;

  mpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  mpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .max_iter (cfg.max_iterations),
    .status   (status),
    .cmd      (cmd)
  );

  mpe_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .pixel_x    (s_tdata[COORD_BITS-1:0]),
    .pixel_y    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_x      (out_x),
    .out_y      (out_y),
    .inside_res (inside_res)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = OUT_W'({inside_res, out_y, out_x});

endmodule

FILE: tb/tb_mandelbrot_pixel_escape.sv
`timescale 1ns / 1ps
// Self-checking testbench for mandelbrot_pixel_escape: streams pixel coordinates
// in, predicts each escape verdict in fixed point and checks the output stream.
// Depends on mpe_pkg and the mandelbrot_pixel_escape top level.
module tb_mandelbrot_pixel_escape;

  localparam int CLK_PERIOD = 12;
  localparam int PIX_BITS = 12;
  localparam int FRAC = mpe_pkg::FRAC_BITS;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam longint WORD_HI = (longint'(1) << (mpe_pkg::WORD_BITS - 1)) - 1;
  localparam longint WORD_LO = -WORD_HI - 1;
  localparam longint ESCAPE_R2 = 4 * ONE_Q;
  localparam longint PROD_LIM = longint'(1) << 61;
  localparam logic [2:0] REG_UNMAPPED = 3'd6;
  localparam int MAX_PAUSE = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int VIEW_PHASES = 10;
  localparam int VIEW_ITEMS = 83;
  localparam int TAIL_CAP = 1000;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [PIX_BITS-1:0] y;
    logic [PIX_BITS-1:0] x;
  } pixel_t;

  typedef struct {
    logic [PIX_BITS-1:0] x;
    logic [PIX_BITS-1:0] y;
    logic                in_set;
  } verdict_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  // pixel_x, pixel_y from bit 0 up
  logic [8*((2*PIX_BITS+7)/8)-1:0]       s_tdata = '0;
  logic                                  s_tvalid = 1'b0;
  logic                                  s_tready;
  // out_x, out_y, inside_res from bit 0 up
  logic [8*((2*PIX_BITS+8)/8)-1:0]       m_tdata;
  logic                                  m_tvalid;
  logic                                  m_tready = 1'b0;
  logic                                  psel = 1'b0;
  logic                                  penable = 1'b0;
  logic                                  pwrite = 1'b0;
  logic [mpe_pkg::ADDR_BITS-1:0]         paddr = '0;
  logic [31:0]                           pwdata = '0;
  logic [31:0]                           prdata;
  logic                                  pready;

  // Shadow of the register file, as the block should hold it.
  mpe_pkg::cfg_t view_cfg;

  pixel_t   pixel_q[$];
  verdict_t verdict_q[$];

  int     queued_count = 0;
  int     results_seen = 0;
  int     error_count = 0;
  int     settings_written = 0;
  int     in_set_count = 0;
  int     escaped_count = 0;
  int     stalled_in_hold = 0;
  longint cycle_count = 0;

  bit          pixel_taken = 1'b0;
  bit          result_taken = 1'b0;
  bit          src_calm = 1'b0;
  bit          snk_calm = 1'b1;
  int unsigned src_pause = 0;
  int unsigned snk_pause = 0;
  logic        hold_active = 1'b0;

  logic                            drive_valid;
  logic [8*((2*PIX_BITS+7)/8)-1:0] drive_data;
  logic                            drive_ready;
  pixel_t                          accepted_px;
  verdict_t                        pending;
  verdict_t                        want;
  logic [PIX_BITS-1:0]             got_x;
  logic [PIX_BITS-1:0]             got_y;
  logic                            got_in;

  mandelbrot_pixel_escape #(
    .COORD_BITS(PIX_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Product at double width, shifted back with floor rounding, clamped to +-2^61.
  function automatic longint fix_mul(input longint a, input longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    wa = a;
    wb = b;
    prod = (wa * wb) >>> FRAC;
    if (prod > PROD_LIM) return PROD_LIM;
    if (prod < -PROD_LIM) return -PROD_LIM;
    return prod[63:0];
  endfunction

  function automatic longint word_clip(input longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // Escape-time test for one pixel under the given register settings.
  function automatic logic predict_in_set(input pixel_t px, input mpe_pkg::cfg_t c);
    longint left_re, top_im, scale, xv, yv, re_inc, im_dec;
    longint c_re, c_im, zr, zi, zr2, zi2, zrzi2;
    int     n;
    left_re = $signed(c.min_re);
    top_im = $signed(c.max_im);
    scale = c.zoom_scale;
    xv = px.x;
    yv = px.y;
    re_inc = c.re_step;
    im_dec = c.im_step;
    c_re = word_clip(fix_mul(left_re + xv * re_inc, scale));
    c_im = word_clip(fix_mul(top_im - yv * im_dec, scale));
    zr = c_re;
    zi = c_im;
    for (n = 0; n < int'(c.max_iterations); n++) begin
      zr2 = fix_mul(zr, zr);
      zi2 = fix_mul(zi, zi);
      if (zr2 + zi2 > ESCAPE_R2) return 1'b0;
      zrzi2 = fix_mul(zr * 2, zi);
      zi = word_clip(zrzi2 + c_im);
      zr = word_clip(zr2 - zi2 + c_re);
    end
    return 1'b1;
  endfunction

  function automatic void apply_setting(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      mpe_pkg::REG_MIN_RE:     view_cfg.min_re = value;
      mpe_pkg::REG_MAX_IM:     view_cfg.max_im = value;
      mpe_pkg::REG_RE_STEP:    view_cfg.re_step = value[30:0];
      mpe_pkg::REG_IM_STEP:    view_cfg.im_step = value[30:0];
      mpe_pkg::REG_ZOOM_SCALE: view_cfg.zoom_scale = value[30:0];
      mpe_pkg::REG_MAX_ITER:   view_cfg.max_iterations = value[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] setting_value(input logic [2:0] idx);
    case (idx)
      mpe_pkg::REG_MIN_RE:     return view_cfg.min_re;
      mpe_pkg::REG_MAX_IM:     return view_cfg.max_im;
      mpe_pkg::REG_RE_STEP:    return {1'b0, view_cfg.re_step};
      mpe_pkg::REG_IM_STEP:    return {1'b0, view_cfg.im_step};
      mpe_pkg::REG_ZOOM_SCALE: return {1'b0, view_cfg.zoom_scale};
      mpe_pkg::REG_MAX_ITER:   return {16'b0, view_cfg.max_iterations};
      default:                 return '0;
    endcase
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, what);
  endtask

  // Register write, then a read back of any mapped register.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_setting(idx, value);
    settings_written++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= mpe_pkg::REG_MAX_ITER) begin
      @(negedge clk);
      psel <= 1'b1;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== setting_value(idx))
        flag_error($sformatf("register %0d reads %h, expected %h", idx, prdata,
                             setting_value(idx)));
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic push_pixel(input logic [PIX_BITS-1:0] x, input logic [PIX_BITS-1:0] y);
    pixel_t px;
    px.x = x;
    px.y = y;
    pixel_q.push_back(px);
    queued_count++;
  endtask

  // Every queued pixel has produced its result.
  task automatic wait_idle();
    while (results_seen != queued_count) @(negedge clk);
  endtask

  // One view: reset, wholly random or classic-set registers, then random pixels.
  task automatic view_phase(input int ph);
    logic [31:0] lo_re, hi_im, stp_re, stp_im, zm, lim;
    int          i;
    if (ph == VIEW_PHASES - 1) begin
      lo_re = 32'hE000_0000;
      hi_im = 32'h1000_0000;
      stp_re = 32'd786432;
      stp_im = 32'd786432;
      zm = 32'h1000_0000;
      lim = 32'd256;
    end else if (ph % 4 == 3) begin
      lo_re = $urandom;
      hi_im = $urandom;
      stp_re = $urandom;
      stp_im = $urandom;
      zm = $urandom;
      lim = $urandom_range(0, 24);
    end else begin
      lo_re = 32'hDC00_0000 + $urandom_range(0, 32'h0800_0000);
      hi_im = 32'h1400_0000 + $urandom_range(0, 32'h0800_0000);
      stp_re = $urandom_range(150000, 230000);
      stp_im = $urandom_range(150000, 230000);
      zm = (ph % 4 == 2) ? $urandom_range(32'h0400_0000, 32'h2000_0000) : 32'h1000_0000;
      lim = (ph == 5) ? $urandom_range(200, 300) : $urandom_range(1, 48);
    end
    reg_write(mpe_pkg::REG_MIN_RE, lo_re);
    reg_write(mpe_pkg::REG_MAX_IM, hi_im);
    reg_write(mpe_pkg::REG_RE_STEP, stp_re);
    reg_write(mpe_pkg::REG_IM_STEP, stp_im);
    reg_write(mpe_pkg::REG_ZOOM_SCALE, zm);
    reg_write(mpe_pkg::REG_MAX_ITER, lim);
    for (i = 0; i < VIEW_ITEMS; i++)
      push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    wait_idle();
  endtask

  // Input side: record each transfer and predict its verdict.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      pixel_taken = 1'b1;
      accepted_px = s_tdata;
      pending.x = accepted_px.x;
      pending.y = accepted_px.y;
      pending.in_set = predict_in_set(accepted_px, view_cfg);
      verdict_q.push_back(pending);
    end
  end

  // Pixel driver: one transfer at a time, random pauses in busy stretches.
  always @(negedge clk) begin
    drive_valid = s_tvalid;
    drive_data = s_tdata;
    if (rst) begin
      drive_valid = 1'b0;
    end else begin
      if (pixel_taken) begin
        pixel_taken = 1'b0;
        drive_valid = 1'b0;
      end
      if (!drive_valid) begin
        if (src_pause > 0) begin
          src_pause--;
        end else if (pixel_q.size() != 0) begin
          drive_data = pixel_q.pop_front();
          drive_valid = 1'b1;
          if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
          src_pause = src_calm ? 0 : $urandom_range(0, MAX_PAUSE);
        end
      end
    end
    s_tvalid <= drive_valid;
    s_tdata <= drive_data;
  end

  // Result sink: random stalls after transfers in busy stretches, or the long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      drive_ready = 1'b0;
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        if ($urandom_range(0, 31) == 0) snk_calm = !snk_calm;
        snk_pause = snk_calm ? 0 : $urandom_range(0, MAX_PAUSE);
      end
      if (hold_active) begin
        drive_ready = 1'b0;
      end else if (snk_pause > 0) begin
        snk_pause--;
        drive_ready = 1'b0;
      end else begin
        drive_ready = 1'b1;
      end
    end
    m_tready <= drive_ready;
  end

  // Output checker: each result against the oldest predicted verdict.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      result_taken = 1'b1;
      results_seen++;
      got_x = m_tdata[PIX_BITS-1:0];
      got_y = m_tdata[2*PIX_BITS-1:PIX_BITS];
      got_in = m_tdata[2*PIX_BITS];
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("result (%0d,%0d) in_set=%b with nothing expected",
                             got_x, got_y, got_in));
      end else begin
        want = verdict_q.pop_front();
        if (got_x !== want.x)
          flag_error($sformatf("out_x %0d, expected %0d", got_x, want.x));
        if (got_y !== want.y)
          flag_error($sformatf("out_y %0d, expected %0d", got_y, want.y));
        if (got_in !== want.in_set)
          flag_error($sformatf("inside_res %b for (%0d,%0d), expected %b",
                               got_in, want.x, want.y, want.in_set));
        if (want.in_set) in_set_count++;
        else escaped_count++;
      end
    end
    if (hold_active && s_tvalid && !s_tready) stalled_in_hold++;
  end

  // Long output hold-off so the block fills up and backs up its input.
  initial begin
    while (results_seen < 30) @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, queued_count - results_seen);
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    int tail;
    view_cfg.min_re = 32'hE000_0000;
    view_cfg.max_im = 32'h1000_0000;
    view_cfg.re_step = 31'd786432;
    view_cfg.im_step = 31'd786432;
    view_cfg.zoom_scale = 31'h1000_0000;
    view_cfg.max_iterations = 16'd256;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset view: corners, edges that saturate, points in and near the cardioid.
    push_pixel(0, 0);
    push_pixel(4095, 0);
    push_pixel(0, 4095);
    push_pixel(4095, 4095);
    push_pixel(85, 341);
    push_pixel(170, 341);
    push_pixel(12'hAAA, 12'h555);
    push_pixel(12'h555, 12'hAAA);
    push_pixel(0, 341);
    push_pixel(100, 300);
    push_pixel(120, 341);
    push_pixel(2048, 2048);
    wait_idle();

    // Extreme registers and a zero iteration limit: every point counts as inside.
    reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    reg_write(mpe_pkg::REG_MIN_RE, 32'h8000_0000);
    reg_write(mpe_pkg::REG_MAX_IM, 32'h7FFF_FFFF);
    reg_write(mpe_pkg::REG_RE_STEP, 32'hFFFF_FFFF);
    reg_write(mpe_pkg::REG_IM_STEP, 32'hFFFF_FFFF);
    reg_write(mpe_pkg::REG_ZOOM_SCALE, 32'hFFFF_FFFF);
    reg_write(mpe_pkg::REG_MAX_ITER, 32'h0000_0000);
    push_pixel(0, 0);
    push_pixel(4095, 0);
    push_pixel(0, 4095);
    push_pixel(4095, 4095);
    wait_idle();

    // One step: saturated coordinates escape at once.
    reg_write(mpe_pkg::REG_MAX_ITER, 32'd1);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    wait_idle();

    // Zero zoom folds every pixel onto the origin.
    reg_write(mpe_pkg::REG_ZOOM_SCALE, 32'h0000_0000);
    reg_write(mpe_pkg::REG_MAX_ITER, 32'd3);
    push_pixel(4095, 0);
    wait_idle();

    // Full iteration limit: the origin runs every step, a far point escapes.
    reg_write(mpe_pkg::REG_MIN_RE, 32'h0000_0000);
    reg_write(mpe_pkg::REG_MAX_IM, 32'h0000_0000);
    reg_write(mpe_pkg::REG_RE_STEP, 32'h0010_0000);
    reg_write(mpe_pkg::REG_IM_STEP, 32'h0010_0000);
    reg_write(mpe_pkg::REG_ZOOM_SCALE, 32'h1000_0000);
    reg_write(mpe_pkg::REG_MAX_ITER, 32'h0000_FFFF);
    push_pixel(0, 0);
    push_pixel(4095, 0);
    wait_idle();

    for (int ph = 0; ph < VIEW_PHASES; ph++) view_phase(ph);

    // Let any stray result show up before the verdict.
    tail = 2 * int'(view_cfg.max_iterations) + 16;
    if (tail > TAIL_CAP) tail = TAIL_CAP;
    repeat (tail) @(posedge clk);
    if (verdict_q.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", verdict_q.size()));

    $display("Covered %0d pixels under %0d register writes: %0d inside, %0d escaped.",
             results_seen, settings_written, in_set_count, escaped_count);
    $display("Input was held off for %0d cycles by the output stall; %0d mismatches.",
             stalled_in_hold, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
